// ===== hw/rtl/smcp_pkg.sv =====
// Shared types and constants for the symbolic mode clause parser.
package smcp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [8:0]  UMASK_RESET = 9'o022;
    localparam logic [12:0] OCT_LIMIT   = 13'o7777;
    localparam logic [12:0] OCT_SAT     = 13'o10000;

    // Token kinds produced by the front classifier
    localparam logic [2:0] TK_END   = 3'd0;
    localparam logic [2:0] TK_COMMA = 3'd1;
    localparam logic [2:0] TK_DIGIT = 3'd2;
    localparam logic [2:0] TK_SEL   = 3'd3;
    localparam logic [2:0] TK_OP    = 3'd4;
    localparam logic [2:0] TK_PERM  = 3'd5;
    localparam logic [2:0] TK_BAD   = 3'd6;

    // Permission letter codes
    localparam logic [3:0] PM_R  = 4'd0;
    localparam logic [3:0] PM_W  = 4'd1;
    localparam logic [3:0] PM_X  = 4'd2;
    localparam logic [3:0] PM_S  = 4'd3;
    localparam logic [3:0] PM_T  = 4'd4;
    localparam logic [3:0] PM_XC = 4'd5;

    // Clause operations
    localparam logic [1:0] OP_ASSIGN = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Class selector masks
    localparam logic [2:0] CL_USER  = 3'b100;
    localparam logic [2:0] CL_GROUP = 3'b010;
    localparam logic [2:0] CL_OTHER = 3'b001;
    localparam logic [2:0] CL_ALL   = 3'b111;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] val;
    } t_tok;

endpackage

// ===== hw/rtl/smcp_front.sv =====
// Front end: classifies each incoming character into a token.
module smcp_front
    import smcp_pkg::*;
(
    input  logic [7:0] i_ch,
    output t_tok       o_tok
);

    always_comb begin
        o_tok.kind = TK_BAD;
        o_tok.val  = 4'd0;
        if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            o_tok.kind = TK_DIGIT;
            o_tok.val  = i_ch[3:0];
        end else begin
            case (i_ch)
                8'h00: o_tok.kind = TK_END;
                8'h2c: o_tok.kind = TK_COMMA;
                8'h75: begin o_tok.kind = TK_SEL;  o_tok.val = {1'b0, CL_USER};   end
                8'h67: begin o_tok.kind = TK_SEL;  o_tok.val = {1'b0, CL_GROUP};  end
                8'h6f: begin o_tok.kind = TK_SEL;  o_tok.val = {1'b0, CL_OTHER};  end
                8'h61: begin o_tok.kind = TK_SEL;  o_tok.val = {1'b0, CL_ALL};    end
                8'h3d: begin o_tok.kind = TK_OP;   o_tok.val = {2'b0, OP_ASSIGN}; end
                8'h2b: begin o_tok.kind = TK_OP;   o_tok.val = {2'b0, OP_ADD};    end
                8'h2d: begin o_tok.kind = TK_OP;   o_tok.val = {2'b0, OP_REMOVE}; end
                8'h72: begin o_tok.kind = TK_PERM; o_tok.val = PM_R;  end
                8'h77: begin o_tok.kind = TK_PERM; o_tok.val = PM_W;  end
                8'h78: begin o_tok.kind = TK_PERM; o_tok.val = PM_X;  end
                8'h73: begin o_tok.kind = TK_PERM; o_tok.val = PM_S;  end
                8'h74: begin o_tok.kind = TK_PERM; o_tok.val = PM_T;  end
                8'h58: begin o_tok.kind = TK_PERM; o_tok.val = PM_XC; end
                default: o_tok.kind = TK_BAD;
            endcase
        end
    end

endmodule

// ===== hw/rtl/smcp_queue.sv =====
// Token queue between the front classifier and the back parser.
module smcp_queue
    import smcp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_tok o_tok
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_tok          r_mem [DEPTH];
    logic [IW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_tok      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_nonempty |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/smcp_back.sv =====
// Back end: clause state machine, umask register and result register.
module smcp_back
    import smcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_tok_valid,
    input  t_tok        i_tok,
    output logic        o_tok_pop,
    output logic [11:0] o_mode_bits,
    output logic [1:0]  o_operation,
    output logic        o_cond_exec,
    output logic        o_status,
    output logic        o_last,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_OCTAL = 2'd1;
    localparam logic [1:0] PH_SEL   = 2'd2;
    localparam logic [1:0] PH_PERM  = 2'd3;

    logic [8:0]  r_umask;
    logic [1:0]  r_phase,   n_phase;
    logic [2:0]  r_class,   n_class;
    logic [1:0]  r_op,      n_op;
    logic [2:0]  r_perm,    n_perm;
    logic [2:0]  r_special, n_special;
    logic        r_xcond,   n_xcond;
    logic        r_mask,    n_mask;
    logic [12:0] r_octal,   n_octal;
    logic        r_err,     n_err;

    logic        r_out_valid, n_out_valid;
    logic [11:0] r_out_mode,  n_out_mode;
    logic [1:0]  r_out_op,    n_out_op;
    logic        r_out_cx,    n_out_cx;
    logic        r_out_st,    n_out_st;
    logic        r_out_last,  n_out_last;

    logic        fin_bad;
    logic [11:0] fin_mode;
    logic [1:0]  fin_op;
    logic        fin_cx;
    logic [2:0]  fin_p, fin_sp;
    logic [15:0] oct_next;

    assign o_tok_pop = i_tok_valid && (!r_out_valid || i_out_ready);

    // Clause result from the current state
    always_comb begin
        fin_bad  = r_err;
        fin_mode = 12'd0;
        fin_op   = OP_ASSIGN;
        fin_cx   = 1'b0;
        fin_p    = r_perm;
        fin_sp   = r_special;
        if (!r_err) begin
            case (r_phase)
                PH_OCTAL: begin
                    if (r_octal > OCT_LIMIT) begin
                        fin_bad = 1'b1;
                    end else begin
                        fin_mode = r_octal[11:0];
                    end
                end
                PH_PERM: begin
                    fin_op = r_op;
                    // Empty assign turns into removal of everything in the classes
                    if (r_perm == 3'd0 && r_special == 3'd0 && r_op == OP_ASSIGN) begin
                        fin_op = OP_REMOVE;
                        fin_p  = 3'b111;
                        fin_sp = r_class;
                    end
                    fin_mode = {fin_sp,
                                r_class[2] ? fin_p : 3'd0,
                                r_class[1] ? fin_p : 3'd0,
                                r_class[0] ? fin_p : 3'd0};
                    if (r_mask) begin
                        fin_mode = fin_mode & ~{3'd0, r_umask};
                    end
                    fin_cx = r_xcond;
                end
                default: fin_bad = 1'b1;
            endcase
        end
        if (fin_bad) begin
            fin_mode = 12'd0;
            fin_op   = OP_ASSIGN;
            fin_cx   = 1'b0;
        end
    end

    assign oct_next = {r_octal, 3'd0} + {12'd0, i_tok.val};

    always_comb begin
        n_phase     = r_phase;
        n_class     = r_class;
        n_op        = r_op;
        n_perm      = r_perm;
        n_special   = r_special;
        n_xcond     = r_xcond;
        n_mask      = r_mask;
        n_octal     = r_octal;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_mode  = r_out_mode;
        n_out_op    = r_out_op;
        n_out_cx    = r_out_cx;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        if (o_tok_pop) begin
            if (i_tok.kind == TK_END || i_tok.kind == TK_COMMA) begin
                n_out_valid = 1'b1;
                n_out_mode  = fin_mode;
                n_out_op    = fin_op;
                n_out_cx    = fin_cx;
                n_out_st    = fin_bad;
                n_out_last  = (i_tok.kind == TK_END);
                n_phase     = PH_START;
                n_class     = 3'd0;
                n_op        = OP_ASSIGN;
                n_perm      = 3'd0;
                n_special   = 3'd0;
                n_xcond     = 1'b0;
                n_mask      = 1'b0;
                n_octal     = 13'd0;
                n_err       = (i_tok.kind == TK_END) ? 1'b0 : fin_bad;
            end else if (!r_err) begin
                if (r_phase == PH_OCTAL) begin
                    if (i_tok.kind == TK_DIGIT && i_tok.val <= 4'd7) begin
                        // saturate so the limit check still sees an overflow
                        n_octal = (oct_next > {3'd0, OCT_SAT}) ? OCT_SAT : oct_next[12:0];
                    end else begin
                        n_err = 1'b1;
                    end
                end else begin
                    case (i_tok.kind)
                        TK_DIGIT: begin
                            if (r_phase == PH_START && i_tok.val <= 4'd7) begin
                                n_phase = PH_OCTAL;
                                n_octal = {9'd0, i_tok.val};
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        TK_SEL: begin
                            if (r_phase == PH_PERM) begin
                                n_err = 1'b1;
                            end else begin
                                n_phase = PH_SEL;
                                n_class = r_class | i_tok.val[2:0];
                            end
                        end
                        TK_OP: begin
                            if (r_phase == PH_PERM) begin
                                n_err = 1'b1;
                            end else begin
                                if (r_phase == PH_START) begin
                                    n_class = CL_ALL;
                                    n_mask  = 1'b1;
                                end
                                n_op    = i_tok.val[1:0];
                                n_phase = PH_PERM;
                            end
                        end
                        TK_PERM: begin
                            if (r_phase != PH_PERM) begin
                                n_err = 1'b1;
                            end else begin
                                case (i_tok.val)
                                    PM_R:    n_perm    = r_perm | 3'b100;
                                    PM_W:    n_perm    = r_perm | 3'b010;
                                    PM_X:    n_perm    = r_perm | 3'b001;
                                    PM_T:    n_special = r_special | 3'b001;
                                    PM_XC:   n_xcond   = 1'b1;
                                    PM_S:    n_special = r_special | (r_class & 3'b110);
                                    default: n_err     = 1'b1;
                                endcase
                            end
                        end
                        default: n_err = 1'b1;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_umask     <= UMASK_RESET;
            r_phase     <= PH_START;
            r_class     <= 3'd0;
            r_op        <= OP_ASSIGN;
            r_perm      <= 3'd0;
            r_special   <= 3'd0;
            r_xcond     <= 1'b0;
            r_mask      <= 1'b0;
            r_octal     <= 13'd0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_umask <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_class     <= n_class;
            r_op        <= n_op;
            r_perm      <= n_perm;
            r_special   <= n_special;
            r_xcond     <= n_xcond;
            r_mask      <= n_mask;
            r_octal     <= n_octal;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_mode <= n_out_mode;
        r_out_op   <= n_out_op;
        r_out_cx   <= n_out_cx;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_mode_bits = r_out_mode;
    assign o_operation = r_out_op;
    assign o_cond_exec = r_out_cx;
    assign o_status    = r_out_st;
    assign o_last      = r_out_last;

`ifndef ASSERT_OFF
    a_bad_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st) |->
            (r_out_mode == 12'd0 && r_out_op == OP_ASSIGN && !r_out_cx))
        else $error("invalid clause carries nonzero fields");
    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_op != 2'd3))
        else $error("undefined operation code");
    a_octal_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_octal <= OCT_SAT)
        else $error("octal accumulator above saturation");
    a_err_cleared_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && i_tok.kind == TK_END) |=> (!r_err && r_phase == PH_START))
        else $error("string end did not clear clause state");
`endif

endmodule

// ===== hw/rtl/symbolic_mode_clause_parser_top.sv =====
// Top level of the symbolic mode clause parser.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_ch
//  out      output     o_out_valid / i_out_ready  o_mode_bits o_operation o_cond_exec
//                                                 o_status o_last
//  cfg      input      i_cfg_wr_en                i_cfg_wr_data (umask)
//
// One character per cycle sustained while the output is not stalled; a character is
// classified by the front end into the token queue, and a back parser step then folds
// it into the clause state or, for a comma or the end, into the result register.
// The clause state machine in the back end sets the rate: one token per cycle unless the output stalls.
// Reset is synchronous and active low; it empties the queue, clears the clause
// state and loads the umask with 022. A stalled output blocks the back end and the
// queue then absorbs up to DEPTH characters before o_in_ready drops.
module symbolic_mode_clause_parser_top
    import smcp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_mode_bits,
    output logic [1:0]  o_operation,
    output logic        o_cond_exec,
    output logic        o_status,
    output logic        o_last
);

    t_tok front_tok;
    t_tok queue_tok;
    logic queue_full;
    logic queue_nonempty;
    logic tok_pop;

    assign o_in_ready = !queue_full;

    smcp_front u_front (
        .i_ch  (i_ch),
        .o_tok (front_tok)
    );

    smcp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in_valid && !queue_full),
        .i_tok      (front_tok),
        .o_full     (queue_full),
        .i_pop      (tok_pop),
        .o_nonempty (queue_nonempty),
        .o_tok      (queue_tok)
    );

    smcp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tok_valid   (queue_nonempty),
        .i_tok         (queue_tok),
        .o_tok_pop     (tok_pop),
        .o_mode_bits   (o_mode_bits),
        .o_operation   (o_operation),
        .o_cond_exec   (o_cond_exec),
        .o_status      (o_status),
        .o_last        (o_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the symbolic mode clause parser.
module tb;
    import smcp_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 6;

    typedef enum logic [1:0] {ST_START, ST_OCTAL, ST_SEL, ST_PERM} t_phase;

    typedef struct packed {
        logic [11:0] mode;
        logic [1:0]  op;
        logic        cx;
        logic        status;
        logic        last;
    } t_clause;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [8:0]  i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_ch;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [11:0] o_mode_bits;
    logic [1:0]  o_operation;
    logic        o_cond_exec;
    logic        o_status;
    logic        o_last;

    // Parser state mirrored by the predictor
    t_phase      ps_phase;
    logic [2:0]  ps_cls;
    logic [1:0]  ps_op;
    logic [2:0]  ps_perm;
    logic [2:0]  ps_spec;
    logic        ps_xcond;
    logic        ps_mask_on;
    logic [12:0] ps_oct;
    logic        ps_err;
    logic [8:0]  ps_umask;

    t_clause pending_clauses[$];
    int      err_count;
    int      sent_count;
    bit      sender_idles;
    bit      receiver_stalls;
    bit      hold_req;

    symbolic_mode_clause_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_ch          (i_ch),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mode_bits   (o_mode_bits),
        .o_operation   (o_operation),
        .o_cond_exec   (o_cond_exec),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function void clear_clause();
        ps_phase   = ST_START;
        ps_cls     = 3'b000;
        ps_op      = OP_ASSIGN;
        ps_perm    = 3'b000;
        ps_spec    = 3'b000;
        ps_xcond   = 1'b0;
        ps_mask_on = 1'b0;
        ps_oct     = '0;
    endfunction

    function t_clause close_clause(input logic is_last);
        t_clause     r;
        logic [2:0]  p;
        logic [2:0]  sp;
        logic [1:0]  o;
        logic [11:0] m;
        logic        cx;
        logic        bad;
        bad = ps_err;
        m   = '0;
        o   = OP_ASSIGN;
        cx  = 1'b0;
        if (!bad) begin
            if (ps_phase == ST_OCTAL) begin
                if (ps_oct > OCT_LIMIT) bad = 1'b1;
                else m = ps_oct[11:0];
            end else if (ps_phase == ST_PERM) begin
                p  = ps_perm;
                sp = ps_spec;
                o  = ps_op;
                // bare assign strips rwx and the special bit of each class
                if (p == 3'b000 && sp == 3'b000 && o == OP_ASSIGN) begin
                    o  = OP_REMOVE;
                    p  = 3'b111;
                    sp = ps_cls;
                end
                if ((ps_cls & CL_OTHER) != 3'b000) m[2:0] = p;
                if ((ps_cls & CL_GROUP) != 3'b000) m[5:3] = p;
                if ((ps_cls & CL_USER) != 3'b000)  m[8:6] = p;
                m[11:9] = sp;
                if (ps_mask_on) m = m & ~{3'b000, ps_umask};
                cx = ps_xcond;
            end else begin
                bad = 1'b1;
            end
        end
        if (bad) begin
            ps_err = 1'b1;
            m  = '0;
            o  = OP_ASSIGN;
            cx = 1'b0;
        end
        r.mode   = m;
        r.op     = o;
        r.cx     = cx;
        r.status = bad;
        r.last   = is_last;
        return r;
    endfunction

    function void take_char(input logic [7:0] c);
        int v;
        if (ps_err) return;
        if (ps_phase == ST_OCTAL) begin
            if (c >= "0" && c <= "7") begin
                v = int'(ps_oct) * 8 + int'(c) - int'("0");
                ps_oct = (v > int'(OCT_SAT)) ? OCT_SAT : 13'(v);
            end else begin
                ps_err = 1'b1;
            end
            return;
        end
        if (ps_phase == ST_START && c >= "0" && c <= "9") begin
            if (c <= "7") begin
                ps_phase = ST_OCTAL;
                ps_oct   = 13'(c - "0");
            end else begin
                ps_err = 1'b1;
            end
            return;
        end
        case (c)
            "u", "g", "o", "a": begin
                if (ps_phase == ST_PERM) begin
                    ps_err = 1'b1;
                end else begin
                    ps_phase = ST_SEL;
                    case (c)
                        "u":     ps_cls = ps_cls | CL_USER;
                        "g":     ps_cls = ps_cls | CL_GROUP;
                        "o":     ps_cls = ps_cls | CL_OTHER;
                        default: ps_cls = CL_ALL;
                    endcase
                end
            end
            "=", "+", "-": begin
                if (ps_phase == ST_PERM) begin
                    ps_err = 1'b1;
                end else begin
                    if (ps_phase == ST_START) begin
                        ps_cls     = CL_ALL;
                        ps_mask_on = 1'b1;
                    end
                    ps_op    = (c == "=") ? OP_ASSIGN : (c == "+") ? OP_ADD : OP_REMOVE;
                    ps_phase = ST_PERM;
                end
            end
            "r", "w", "x", "s", "t", "X": begin
                if (ps_phase != ST_PERM) begin
                    ps_err = 1'b1;
                end else begin
                    case (c)
                        "r": ps_perm = ps_perm | 3'b100;
                        "w": ps_perm = ps_perm | 3'b010;
                        "x": ps_perm = ps_perm | 3'b001;
                        "t": ps_spec = ps_spec | 3'b001;
                        "X": ps_xcond = 1'b1;
                        default: begin
                            if ((ps_cls & CL_USER) != 3'b000)  ps_spec = ps_spec | 3'b100;
                            if ((ps_cls & CL_GROUP) != 3'b000) ps_spec = ps_spec | 3'b010;
                        end
                    endcase
                end
            end
            default: ps_err = 1'b1;
        endcase
    endfunction

    function void step_parser(input logic [7:0] c, output bit has, output t_clause r);
        has = 1'b0;
        r   = '0;
        if (c == 8'h00) begin
            r = close_clause(1'b1);
            clear_clause();
            ps_err = 1'b0;
            has = 1'b1;
        end else if (c == ",") begin
            r = close_clause(1'b0);
            clear_clause();
            has = 1'b1;
        end else begin
            take_char(c);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= 40)
            $display("tb: mismatch %s got %0h expected %0h at %0t",
                     what, got, want, $realtime);
    endtask

    task automatic send_char(input logic [7:0] c);
        bit      has;
        t_clause r;
        int      gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_ch       = 8'($urandom_range(0, 255));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_ch       = c;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
        step_parser(c, has, r);
        if (has) pending_clauses.push_back(r);
    endtask

    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
        send_char(8'h00);
    endtask

    // Drop valid and let the block drain every clause in flight.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_clauses.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_umask(input logic [8:0] v);
        wait_quiet();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        ps_umask      = v;
    endtask

    task automatic send_random_clause();
        string      sel_chars  = "ugoa";
        string      op_chars   = "=+-";
        string      perm_chars = "rwxXst";
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 39) == 0) b = 8'("8" + $urandom_range(0, 1));
                else b = 8'("0" + $urandom_range(0, 7));
                send_char(b);
            end
        end else if (pick < 92) begin
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) send_char(sel_chars[$urandom_range(0, 3)]);
            send_char(op_chars[$urandom_range(0, 2)]);
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) send_char(perm_chars[$urandom_range(0, 5)]);
            // break the grammar now and then
            if ($urandom_range(0, 19) == 0) send_char(op_chars[$urandom_range(0, 2)]);
            if ($urandom_range(0, 29) == 0) send_char(sel_chars[$urandom_range(0, 3)]);
        end else begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) send_char(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_random_string();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            if (k > 0) send_char(",");
            send_random_clause();
        end
        send_char(8'h00);
    endtask

    task automatic test_octal_and_empty();
        send_string("");
        send_string("0,7777,10000,17");
        send_string("8,u+r");
        send_string("7a");
        send_char(8'hff);
        send_char(8'h00);
    endtask

    task automatic test_symbolic_ops();
        send_string("ugo+rwxXst,a=s");
        send_string("a=,u=,go=");
        send_string("-w,=rX,+t");
    endtask

    task automatic test_grammar_errors();
        send_string("u+r-w,g+x");
        send_string("+u");
        send_string("u,,o+x");
        send_string("u+q,r");
    endtask

    task automatic test_umask_settings();
        logic [8:0] values [3];
        values[0] = 9'h000;
        values[1] = 9'h1ff;
        values[2] = 9'($urandom_range(0, 511));
        for (int k = 0; k < 3; k++) begin
            set_umask(values[k]);
            send_string("+rwxst,=,-X,u+w");
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        // keep offering while the receiver is held off so the input stalls
        repeat (8) send_string("u+x,g-w,7");
        wait (hold_req == 1'b0);
    endtask

    task automatic test_random_traffic();
        int goal;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_umask(9'h000);
                1:       set_umask(9'h1ff);
                2:       set_umask(9'($urandom_range(0, 511)));
                default: set_umask(UMASK_RESET);
            endcase
            goal = sent_count + (RANDOM_ITEMS * 2) / 10;
            while (sent_count < goal) send_random_string();
        end
    endtask

    task automatic test_streaming();
        int goal;
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        set_umask(9'($urandom_range(0, 511)));
        goal = sent_count + (RANDOM_ITEMS * 2) / 10;
        while (sent_count < goal) send_random_string();
    endtask

    initial begin : receiver
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                n = 0;
                while (n < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    n++;
                end
                hold_req = 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                if (receiver_stalls) repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_clause want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_clauses.size() == 0) begin
                report_mismatch("unexpected clause transaction", 0, 0);
            end else begin
                want = pending_clauses.pop_front();
                if (o_mode_bits !== want.mode)
                    report_mismatch("mode_bits", int'(o_mode_bits), int'(want.mode));
                if (o_operation !== want.op)
                    report_mismatch("operation", int'(o_operation), int'(want.op));
                if (o_cond_exec !== want.cx)
                    report_mismatch("cond_exec", int'(o_cond_exec), int'(want.cx));
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_last !== want.last)
                    report_mismatch("last", int'(o_last), int'(want.last));
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_in_valid      = 1'b0;
        i_ch            = '0;
        i_out_ready     = 1'b0;
        hold_req        = 1'b0;
        err_count       = 0;
        sent_count      = 0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        clear_clause();
        ps_err   = 1'b0;
        ps_umask = UMASK_RESET;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_octal_and_empty();
        test_symbolic_ops();
        test_grammar_errors();
        test_umask_settings();
        test_backpressure();
        test_random_traffic();
        test_streaming();

        wait_quiet();
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/smcp_pkg.sv
hw/rtl/smcp_front.sv
hw/rtl/smcp_queue.sv
hw/rtl/smcp_back.sv
hw/rtl/symbolic_mode_clause_parser_top.sv
tb/tb.sv
